FILE: hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    typedef logic [4:0][31:0] chain_t;

    localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] RND_SCHED  = 7'd16;
    localparam logic [6:0] RND_G1     = 7'd20;
    localparam logic [6:0] RND_G2     = 7'd40;
    localparam logic [6:0] RND_G3     = 7'd60;
    localparam logic [6:0] RND_LAST   = 7'd79;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [2:0] IDX_LAST   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // control from the sequencer to the schedule and round units
    typedef struct packed {
        logic       put;      // shift one byte into the block buffer
        logic [7:0] put_val;
        logic       load;     // block full: load working vars from chain
        logic       step;     // run one round
        logic [6:0] rnd;
    } core_ctrl_t;

endpackage

FILE: hdl/sha1md_sched.sv
// ----------------------------------------------------------------------------
// sha1md_sched
// Block buffer and message schedule as a 16-word circular shift register.
// ----------------------------------------------------------------------------
module sha1md_sched (
    input  logic                   aclk,
    input  sha1md_pkg::core_ctrl_t ctrl,
    output logic [31:0]            wr
);

    logic [511:0] blk_reg;
    logic [31:0]  w0, w2, w8, w13, mix;

    // w0 is the oldest word in the window, w13 the word three rounds back
    assign w0  = blk_reg[511:480];
    assign w2  = blk_reg[447:416];
    assign w8  = blk_reg[255:224];
    assign w13 = blk_reg[95:64];
    assign mix = w13 ^ w8 ^ w2 ^ w0;

    always_comb begin
        if (ctrl.rnd < sha1md_pkg::RND_SCHED) begin
            wr = w0;
        end else begin
            wr = {mix[30:0], mix[31]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.put) begin
            blk_reg <= {blk_reg[503:0], ctrl.put_val};
        end else if (ctrl.step) begin
            blk_reg <= {blk_reg[479:0], wr};
        end
    end

endmodule

FILE: hdl/sha1md_round.sv
// ----------------------------------------------------------------------------
// sha1md_round
// Working variables a..e and the shared round unit, one round per cycle.
// ----------------------------------------------------------------------------
module sha1md_round (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1md_pkg::core_ctrl_t ctrl,
    input  sha1md_pkg::chain_t     chain,
    input  logic [31:0]            wr,
    output sha1md_pkg::chain_t     work
);

    sha1md_pkg::chain_t work_reg;
    logic [31:0] a, b, c, d, e, f, k, t;

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];

    always_comb begin
        if (ctrl.rnd < sha1md_pkg::RND_G1) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K_R0;
        end else if (ctrl.rnd < sha1md_pkg::RND_G2) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_R1;
        end else if (ctrl.rnd < sha1md_pkg::RND_G3) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K_R2;
        end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_R3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + wr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= '0;
        end else if (ctrl.load) begin
            work_reg <= chain;
        end else if (ctrl.step) begin
            work_reg <= {d, c, {b[1:0], b[31:2]}, a, t};
        end
    end

    assign work = work_reg;

endmodule

FILE: hdl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, digest out as five 32-bit words.
// ----------------------------------------------------------------------------
// Input channel (s_): one message byte per item, s_has_byte marks a real
// byte, s_is_last ends the message (it may carry no byte).
// Result channel (m_): after a last item, five items h0..h4, word index 0..4,
// m_last_word set on h4.
// Timing: an item that neither fills the 64-byte block nor ends the message
// leaves s_ready high for the next item. An item that fills the block starts
// a compression: 80 rounds at one round per cycle on the shared round unit
// plus the chaining add in ST_FINAL, with s_ready low throughout. On a last
// item the padding bytes go in (up to 72), with one or two more compressions,
// then the five digest items go out one per cycle while m_ready is high.
// s_ready stays low until the fifth word is taken; a stalled receiver just
// holds the current word. After that the block is idle with the initial chain.
// Reset (aresetn low, synchronous) loads the initial chain, clears the byte
// and bit counts and returns to idle.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha1md_pkg::state_t     state_reg, state_next, ret_reg, ret_next;
    sha1md_pkg::chain_t     chain_reg, work;
    sha1md_pkg::core_ctrl_t ctrl;
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg, len_shift;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic [31:0] wr;
    logic        put, step, wrap, s_acc, m_acc, done;
    logic [7:0]  put_val;

    assign s_acc     = s_valid && s_ready;
    assign m_acc     = m_valid && m_ready;
    assign done      = m_acc && (idx_reg == sha1md_pkg::IDX_LAST);
    assign len_shift = bits_reg << {pos_reg[2:0], 3'b000};
    assign wrap      = put && (pos_reg == sha1md_pkg::POS_LAST);

    // outputs of the sequencer
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        put     = 1'b0;
        put_val = 8'd0;
        step    = 1'b0;
        case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                put     = s_valid && s_has_byte;
                put_val = s_data_byte;
            end
            sha1md_pkg::ST_PAD80: begin
                put     = 1'b1;
                put_val = sha1md_pkg::PAD_BYTE;
            end
            sha1md_pkg::ST_ZERO: begin
                put = (pos_reg != sha1md_pkg::POS_LEN);
            end
            sha1md_pkg::ST_LEN: begin
                put     = 1'b1;
                put_val = len_shift[63:56];
            end
            sha1md_pkg::ST_ROUND: begin
                step = 1'b1;
            end
            sha1md_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // next state; ret_reg holds where to go after a compression
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (wrap) begin
                        state_next = sha1md_pkg::ST_ROUND;
                        ret_next   = s_is_last ? sha1md_pkg::ST_PAD80 : sha1md_pkg::ST_IDLE;
                    end else if (s_is_last) begin
                        state_next = sha1md_pkg::ST_PAD80;
                    end
                end
            end
            sha1md_pkg::ST_PAD80: begin
                if (wrap) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_ZERO;
                end else begin
                    state_next = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_ZERO: begin
                if (pos_reg == sha1md_pkg::POS_LEN) begin
                    state_next = sha1md_pkg::ST_LEN;
                end else if (wrap) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_ZERO;
                end
            end
            sha1md_pkg::ST_LEN: begin
                if (wrap) begin
                    state_next = sha1md_pkg::ST_ROUND;
                    ret_next   = sha1md_pkg::ST_OUT;
                end
            end
            sha1md_pkg::ST_ROUND: begin
                if (rnd_reg == sha1md_pkg::RND_LAST) begin
                    state_next = sha1md_pkg::ST_FINAL;
                end
            end
            sha1md_pkg::ST_FINAL: begin
                state_next = ret_reg;
            end
            sha1md_pkg::ST_OUT: begin
                if (done) begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha1md_pkg::ST_IDLE;
            ret_reg   <= sha1md_pkg::ST_IDLE;
            pos_reg   <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            chain_reg <= sha1md_pkg::H_INIT;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (put) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (done) begin
                bits_reg <= '0;
            end else if (s_acc && s_has_byte) begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (step) begin
                rnd_reg <= (rnd_reg == sha1md_pkg::RND_LAST) ? 7'd0 : rnd_reg + 7'd1;
            end
            if (m_acc) begin
                idx_reg <= done ? 3'd0 : idx_reg + 3'd1;
            end
            if (done) begin
                chain_reg <= sha1md_pkg::H_INIT;
            end else if (state_reg == sha1md_pkg::ST_FINAL) begin
                for (int i = 0; i < 5; i++) begin
                    chain_reg[i] <= chain_reg[i] + work[i];
                end
            end
        end
    end

    always_comb begin
        ctrl.put     = put;
        ctrl.put_val = put_val;
        ctrl.load    = wrap;
        ctrl.step    = step;
        ctrl.rnd     = rnd_reg;
    end

    sha1md_sched u_sched (
        .aclk (aclk),
        .ctrl (ctrl),
        .wr   (wr)
    );

    sha1md_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .chain   (chain_reg),
        .wr      (wr),
        .work    (work)
    );

    assign m_digest_word = chain_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == sha1md_pkg::IDX_LAST);

endmodule

FILE: hdl/sha1md_checker.sv
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
module sha1md_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);

    // the block never takes input while digest words are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted during digest output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) &&
            $stable(m_word_index))
        else $error("stalled digest word changed");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && (m_word_index == 3'($past(m_word_index) + 3'd1)))
        else $error("digest words out of order");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == sha1md_pkg::IDX_LAST)))
        else $error("last flag does not match word index");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_word |=> s_ready && !m_valid)
        else $error("not idle after final digest word");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);

FILE: tb/sha1_message_digest_test.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_test
// Byte-stream SHA-1 check: a directed table (empty message, "abc", edge
// bytes, empty final items), then random messages with boundary lengths.
// Every accepted item goes through a local SHA-1 model and each digest word
// is compared field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module sha1_message_digest_test;

    localparam int NUM_DIR     = 13;
    localparam int ITEM_TARGET = 300;
    localparam int LONG_HOLD   = 400;
    localparam int PRINT_MAX   = 40;

    typedef struct packed {
        logic [7:0]   data;
        logic         has_byte;
        logic         is_last;
        bit           typed;
        logic [159:0] digest;
    } dir_row_t;

    typedef struct packed {
        bit           typed;
        logic [159:0] digest;
    } known_digest_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_word_t;

    // has_byte/is_last rows; digests typed in only for well-known strings
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
        '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hAA, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    // local copy of the hash state
    logic [31:0] chain_h [5];
    logic [31:0] block_w [16];
    logic [5:0]  fill_count;
    logic [63:0] msg_bits;

    digest_word_t  pending_digest_words [$];
    known_digest_t known_digests [$];
    digest_word_t  want;

    int mismatch_count = 0;
    int items_sent = 0;
    bit sender_gapless = 1'b0;
    bit sink_gapless = 1'b0;
    bit hold_off_req = 1'b0;

    sha1_message_digest dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_has_byte    (s_has_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (mismatch_count < PRINT_MAX) begin
            $display("mismatch %s: got %h, want %h", what, got, exp_val);
        end
        mismatch_count++;
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic hash_state_reset();
        int i;
        for (i = 0; i < 5; i++) chain_h[i] = sha1md_pkg::H_INIT[i];
        for (i = 0; i < 16; i++) block_w[i] = 32'h0;
        fill_count = 6'd0;
        msg_bits = 64'd0;
    endtask

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wr, t;
        int r;
        w = block_w;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                wr = rotl32(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^
                            w[r % 16], 1);
                w[r % 16] = wr;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K_R0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_R1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K_R2;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_R3;
            end
            t = rotl32(a, 5) + f + e + k + wr;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // big-endian byte packing; a full block triggers compression
    task automatic absorb_byte(input logic [7:0] v);
        if (fill_count[1:0] == 2'd0) block_w[fill_count[5:2]] = 32'h0;
        block_w[fill_count[5:2]][8 * (3 - fill_count[1:0]) +: 8] = v;
        fill_count = fill_count + 6'd1;
        if (fill_count == 6'd0) compress_block();
    endtask

    task automatic sha1_absorb_item(input logic [7:0] d, input logic h, input logic l);
        logic [63:0]   len;
        known_digest_t kd;
        digest_word_t  dw;
        int i;
        if (h) begin
            absorb_byte(d);
            msg_bits += 64'd8;
        end
        if (l) begin
            len = msg_bits;
            absorb_byte(sha1md_pkg::PAD_BYTE);
            while (fill_count != sha1md_pkg::POS_LEN) absorb_byte(8'h00);
            for (i = 7; i >= 0; i--) absorb_byte(len[8 * i +: 8]);
            kd = '0;
            if (known_digests.size() != 0) kd = known_digests.pop_front();
            for (i = 0; i < 5; i++) begin
                dw.word      = kd.typed ? kd.digest[159 - 32 * i -: 32] : chain_h[i];
                dw.index     = i[2:0];
                dw.last_word = (i[2:0] == sha1md_pkg::IDX_LAST);
                pending_digest_words.push_back(dw);
            end
            hash_state_reset();
        end
    endtask

    // output check first, then any accepted item is absorbed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_digest_words.size() == 0) begin
                    report_mismatch("word with nothing pending", m_digest_word, 32'h0);
                end else begin
                    want = pending_digest_words.pop_front();
                    if (m_digest_word !== want.word)
                        report_mismatch("digest_word", m_digest_word, want.word);
                    if (m_word_index !== want.index)
                        report_mismatch("word_index", {29'h0, m_word_index},
                                        {29'h0, want.index});
                    if (m_last_word !== want.last_word)
                        report_mismatch("last_word", {31'h0, m_last_word},
                                        {31'h0, want.last_word});
                end
            end
            if (s_valid && s_ready) sha1_absorb_item(s_data_byte, s_has_byte, s_is_last);
        end
    end

    task automatic send_item(input logic [7:0] d, input logic h, input logic l);
        int gap;
        gap = sender_gapless ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_has_byte  <= h;
        s_is_last   <= l;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        bit empty_end;
        int n;
        empty_end = (len == 0) || ($urandom_range(0, 3) == 0);
        known_digests.push_back('0);
        for (n = 0; n < len; n++) begin
            if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !empty_end && (n == len - 1));
        end
        if (empty_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // sender goes quiet until every pending digest word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_digest_words.size() != 0);
    endtask

    initial begin : result_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
                gap = 0;
            end else begin
                gap = sink_gapless ? 0 : $urandom_range(0, 14);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if ($urandom_range(0, 9) == 0) sink_gapless = !sink_gapless;
        end
    end

    initial begin : stimulus
        int i;
        int len;
        int msg_no;
        hash_state_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NUM_DIR; i++) begin
            if (DIR_ROWS[i].is_last)
                known_digests.push_back({DIR_ROWS[i].typed, DIR_ROWS[i].digest});
            send_item(DIR_ROWS[i].data, DIR_ROWS[i].has_byte, DIR_ROWS[i].is_last);
        end
        drain_results();

        // 55 bytes: padding fits one block; 56: needs a second; 64: full block first
        msg_no = 0;
        while (items_sent < ITEM_TARGET) begin
            sender_gapless = ($urandom_range(0, 3) == 0);
            case (msg_no)
                0: len = 56;
                3: begin
                    len = 64;
                    hold_off_req = 1'b1;
                end
                6: len = 55;
                default: begin
                    if ($urandom_range(0, 6) == 0) len = $urandom_range(13, 70);
                    else len = $urandom_range(0, 12);
                end
            endcase
            if (msg_no == 9) drain_results();
            send_message(len);
            msg_no++;
        end
        s_valid <= 1'b0;

        while (pending_digest_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sha1_message_digest.f
hdl/sha1md_pkg.sv
hdl/sha1md_sched.sv
hdl/sha1md_round.sv
hdl/sha1_message_digest.sv
hdl/sha1md_checker.sv
tb/sha1_message_digest_test.sv
